FILE: sv/psl_pkg.sv
// Shared types and codes for the positional sorted list table.
package psl_pkg;

	// Operation codes of a request
	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_LOCATE = 2'd2,
		OP_SORTED = 2'd3
	} op_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BADPOS   = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	// Command broadcast to every cell of the chain
	typedef enum logic [1:0] {
		CMD_HOLD    = 2'd0,
		CMD_INSERT  = 2'd1,
		CMD_DELETE  = 2'd2,
		CMD_COMPARE = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t               cmd;
		logic signed [31:0] data;
	} cell_cmd_t;

endpackage

FILE: sv/positional_sorted_list_table.sv
// Top level of the positional sorted list table: controller and cell chain.
// Insert or delete at position, and any rejected request, finish straight from the idle state;
// locate scans up over the registered match flags, one cell per cycle, to a match or the count;
// sorted insert scans down from the count to its landing place, after any equal entries.
// Throughput: the next request is taken in the cycle of the previous result, so positional
// requests run back to back; results cannot be stalled. Reset clears count and controller.
module positional_sorted_list_table import psl_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         op,
	input  logic signed [31:0] data,
	input  logic [4:0]         position,
	output logic               done,
	output logic [1:0]         status,
	output logic [3:0]         index,
	output logic [4:0]         count
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);
	localparam int PW = (CW > 5) ? CW : 5;
	localparam logic [CW-1:0] Cap = CW'(CAPACITY);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN_UP,
		S_SCAN_DN
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      fill_q;
	logic [CW-1:0]      ptr_q;
	logic signed [31:0] data_q;
	logic               done_q;
	status_t            status_q;
	logic [3:0]         index_q;

	cell_cmd_t          cmd;
	logic [CW-1:0]      cmd_pos;
	logic signed [31:0] entry_w [CAPACITY];
	logic [CAPACITY-1:0] eq_w;
	logic [CAPACITY-1:0] gt_w;

	logic [PW-1:0] pos_w;
	logic [PW-1:0] fill_w;
	logic          accept;
	logic          full;
	logic [CW-1:0] ptr_m1;
	logic          land;

	assign accept = start && (state_q == S_IDLE);
	assign pos_w  = PW'(position);
	assign fill_w = PW'(fill_q);
	assign full   = (fill_q >= Cap);
	assign ptr_m1 = ptr_q - CW'(1);
	// Sorted insert lands where the entry below is not greater, or at the bottom
	assign land   = (ptr_q == '0) || !gt_w[ptr_m1[IW-1:0]];

	// Command to the chain
	always_comb begin
		cmd.cmd  = CMD_HOLD;
		cmd.data = data;
		cmd_pos  = CW'(position);
		if (accept) begin
			case (op_t'(op))
				OP_INSERT: if (!(pos_w > fill_w) && !full) cmd.cmd = CMD_INSERT;
				OP_DELETE: if (pos_w < fill_w) cmd.cmd = CMD_DELETE;
				OP_LOCATE: cmd.cmd = CMD_COMPARE;
				OP_SORTED: if (!full) cmd.cmd = CMD_COMPARE;
				default: cmd.cmd = CMD_HOLD;
			endcase
		end else if (state_q == S_SCAN_DN && land) begin
			cmd.cmd  = CMD_INSERT;
			cmd.data = data_q;
			cmd_pos  = ptr_q;
		end
	end

	// Cell chain
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic signed [31:0] left_w;
		logic signed [31:0] right_w;
		if (g == 0) begin : g_first
			assign left_w = entry_w[g];
		end else begin : g_mid
			assign left_w = entry_w[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign right_w = entry_w[g];
		end else begin : g_up
			assign right_w = entry_w[g+1];
		end
		psl_cell #(.CW(CW), .IDX(g)) u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.position (cmd_pos),
			.left     (left_w),
			.right    (right_w),
			.entry    (entry_w[g]),
			.eq       (eq_w[g]),
			.gt       (gt_w[g])
		);
	end

	// Controller: state, count, scan pointer and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			fill_q   <= '0;
			ptr_q    <= '0;
			data_q   <= '0;
			done_q   <= 1'b0;
			status_q <= ST_OK;
			index_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						data_q   <= data;
						index_q  <= '0;
						status_q <= ST_OK;
						case (op_t'(op))
							OP_INSERT: begin
								done_q <= 1'b1;
								if (pos_w > fill_w) begin
									status_q <= ST_BADPOS;
								end else if (full) begin
									status_q <= ST_FULL;
								end else begin
									fill_q <= fill_q + CW'(1);
								end
							end
							OP_DELETE: begin
								done_q <= 1'b1;
								if (pos_w < fill_w) begin
									fill_q <= fill_q - CW'(1);
								end else begin
									status_q <= ST_BADPOS;
								end
							end
							OP_LOCATE: begin
								ptr_q   <= '0;
								state_q <= S_SCAN_UP;
							end
							default: begin
								if (full) begin
									done_q   <= 1'b1;
									status_q <= ST_FULL;
								end else begin
									ptr_q   <= fill_q;
									state_q <= S_SCAN_DN;
								end
							end
						endcase
					end
				end
				S_SCAN_UP: begin
					if (ptr_q >= fill_q) begin
						done_q   <= 1'b1;
						status_q <= ST_NOTFOUND;
						state_q  <= S_IDLE;
					end else if (eq_w[ptr_q[IW-1:0]]) begin
						done_q   <= 1'b1;
						index_q  <= 4'(ptr_q);
						state_q  <= S_IDLE;
					end else begin
						ptr_q <= ptr_q + CW'(1);
					end
				end
				S_SCAN_DN: begin
					if (land) begin
						done_q  <= 1'b1;
						fill_q  <= fill_q + CW'(1);
						state_q <= S_IDLE;
					end else begin
						ptr_q <= ptr_m1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign status = status_q;
	assign index  = index_q;
	assign count  = 5'(fill_q);

	// A result always leaves the controller ready for the next request
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while controller busy");

	// Count never passes capacity
	a_fill_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= Cap) else $error("element count above capacity");

	// Positional requests give their result in the next cycle
	a_pos_one: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (op == OP_INSERT || op == OP_DELETE)) |=> done)
		else $error("positional request not finished in one cycle");

	// Count changes only together with a result
	a_fill_done: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != $past(fill_q)) |-> done) else $error("count changed without result");

endmodule

FILE: sv/psl_cell.sv
// One storage cell of the list chain: holds one entry and its compare flags.
module psl_cell import psl_pkg::*; #(
	parameter int CW  = 5,
	parameter int IDX = 0
) (
	input  logic               clk,
	input  cell_cmd_t          cmd,
	input  logic [CW-1:0]      position,
	input  logic signed [31:0] left,
	input  logic signed [31:0] right,
	output logic signed [31:0] entry,
	output logic               eq,
	output logic               gt
);

	localparam logic [CW-1:0] MyIdx = CW'(IDX);

	logic signed [31:0] entry_q;
	logic               eq_q;
	logic               gt_q;

	// Entry moves with its neighbours on insert and delete
	always_ff @(posedge clk) begin
		case (cmd.cmd)
			CMD_INSERT: begin
				if (MyIdx > position) begin
					entry_q <= left;
				end else if (MyIdx == position) begin
					entry_q <= cmd.data;
				end
			end
			CMD_DELETE: begin
				if (MyIdx >= position) begin
					entry_q <= right;
				end
			end
			default: begin
			end
		endcase
	end

	// Compare flags, captured against the broadcast word
	always_ff @(posedge clk) begin
		if (cmd.cmd == CMD_COMPARE) begin
			eq_q <= (entry_q == cmd.data);
			gt_q <= (entry_q > cmd.data);
		end
	end

	assign entry = entry_q;
	assign eq    = eq_q;
	assign gt    = gt_q;

endmodule

FILE: dv/psl_checker.sv
// Checker for the positional sorted list table: tracks the list, predicts and compares results.
module psl_checker import psl_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [1:0]         op,
	input  logic signed [31:0] data,
	input  logic [4:0]         position,
	input  logic               done,
	input  logic [1:0]         status,
	input  logic [3:0]         index,
	input  logic [4:0]         count,
	output int                 fail_count,
	output int                 pending,
	output logic [4:0]         fill_now
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		status_t    status;
		logic [3:0] index;
		logic [4:0] count;
	} outcome_t;

	// Shadow copy of the list and the results still owed
	logic signed [31:0] list_words [CAPACITY];
	int unsigned        list_fill;
	outcome_t           outcome_q [$];

	// Apply one request to the shadow list and return the result it must give
	function automatic outcome_t apply_request(op_t req_op, logic signed [31:0] word,
	                                           logic [4:0] pos);
		outcome_t res;
		int       k;
		res.status = ST_OK;
		res.index  = '0;
		case (req_op)
			OP_INSERT: begin
				// position check wins over the full check
				if (pos > list_fill) begin
					res.status = ST_BADPOS;
				end else if (list_fill >= CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					for (k = list_fill; k > pos; k--)
						list_words[k] = list_words[k-1];
					list_words[pos] = word;
					list_fill++;
				end
			end
			OP_DELETE: begin
				if (pos >= list_fill) begin
					res.status = ST_BADPOS;
				end else begin
					for (k = pos; k + 1 < list_fill; k++)
						list_words[k] = list_words[k+1];
					list_fill--;
				end
			end
			OP_LOCATE: begin
				// lowest matching index wins; no match leaves index at zero
				res.status = ST_NOTFOUND;
				for (k = 0; k < list_fill; k++) begin
					if (list_words[k] == word) begin
						res.status = ST_OK;
						res.index  = k[3:0];
						break;
					end
				end
			end
			default: begin
				// sorted insert lands after any equal words
				if (list_fill >= CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					k = list_fill;
					while (k > 0 && list_words[k-1] > word) begin
						list_words[k] = list_words[k-1];
						k--;
					end
					list_words[k] = word;
					list_fill++;
				end
			end
		endcase
		res.count = list_fill[4:0];
		return res;
	endfunction

	// Compare each strobed result with the oldest owed one, then log any new request
	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			list_fill  = 0;
			outcome_q.delete();
			fail_count = 0;
			pending    <= 0;
			fill_now   <= '0;
		end else begin
			if (done) begin
				if (outcome_q.size() == 0) begin
					$display("%0t: result with no request outstanding: status %0d index %0d count %0d",
						$time, status, index, count);
					fail_count++;
				end else begin
					want = outcome_q.pop_front();
					if (status !== want.status) begin
						$display("%0t: status expected %0d actual %0d", $time, want.status, status);
						fail_count++;
					end
					if (index !== want.index) begin
						$display("%0t: index expected %0d actual %0d", $time, want.index, index);
						fail_count++;
					end
					if (count !== want.count) begin
						$display("%0t: count expected %0d actual %0d", $time, want.count, count);
						fail_count++;
					end
				end
			end
			if (start && !busy)
				outcome_q.push_back(apply_request(op_t'(op), data, position));
			pending  <= outcome_q.size();
			fill_now <= list_fill[4:0];
		end
	end

endmodule

FILE: dv/tb_positional_sorted_list_table.sv
// Testbench top for the positional sorted list table: clock, reset, requests and verdict.
module tb_positional_sorted_list_table;
	import psl_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY = 16;
	localparam int RANDOM_REQUESTS = 1530;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [1:0]         op = OP_INSERT;
	logic signed [31:0] data = '0;
	logic [4:0]         position = '0;
	logic               busy;
	logic               done;
	logic [1:0]         status;
	logic [3:0]         index;
	logic [4:0]         count;
	int                 fail_count;
	int                 pending;
	logic [4:0]         fill_now;

	// Recently stored words, reused so that locates hit and sorted inserts meet equals
	logic signed [31:0] word_pool [$];

	positional_sorted_list_table #(.CAPACITY(CAPACITY)) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.op       (op),
		.data     (data),
		.position (position),
		.done     (done),
		.status   (status),
		.index    (index),
		.count    (count)
	);

	psl_checker #(.CAPACITY(CAPACITY)) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.op         (op),
		.data       (data),
		.position   (position),
		.done       (done),
		.status     (status),
		.index      (index),
		.count      (count),
		.fail_count (fail_count),
		.pending    (pending),
		.fill_now   (fill_now)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop in case the block hangs
	initial begin
		#5_000_000;
		$display("** positional_sorted_list_table: FAILED **");
		$finish;
	end

	// Present one request and hold it until the block takes it
	task automatic issue(op_t req_op, logic signed [31:0] word, logic [4:0] pos);
		start    <= 1'b1;
		op       <= req_op;
		data     <= word;
		position <= pos;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (req_op == OP_INSERT || req_op == OP_SORTED) begin
			word_pool.push_back(word);
			if (word_pool.size() > 24)
				void'(word_pool.pop_front());
		end
	endtask

	// Drop start for a random number of cycles
	task automatic idle_gap(int pct);
		if ($urandom_range(99) < pct) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < pct);
		end
	endtask

	// Word source: pool reuse, extremes, narrow values for ties, or anything
	function automatic logic signed [31:0] pick_word();
		int r;
		r = $urandom_range(9);
		if (r < 5 && word_pool.size() > 0)
			return word_pool[$urandom_range(word_pool.size() - 1)];
		if (r == 5) begin
			case ($urandom_range(3))
				0: return 32'sh8000_0000;
				1: return 32'sh7fff_ffff;
				2: return 32'sh0000_0000;
				default: return -32'sd1;
			endcase
		end
		if (r <= 7)
			return $signed($urandom_range(15)) - 32'sd8;
		return $urandom;
	endfunction

	initial begin
		int          idle_pct [4] = '{0, 76, 0, 38};
		int          phase;
		int          n;
		int          r;
		int          f;
		int          seg_left;
		bit          growing;
		op_t         req_op;
		logic [4:0]  pos;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty list, bad positions, sorted ties, extremes, locates, deletes
		issue(OP_DELETE, 32'sd0, 5'd0);
		issue(OP_LOCATE, 32'sd7, 5'd0);
		issue(OP_INSERT, 32'sd1, 5'd1);
		issue(OP_INSERT, 32'sd1, 5'd31);
		issue(OP_SORTED, 32'sd0, 5'd0);
		issue(OP_SORTED, 32'sh7fff_ffff, 5'd0);
		issue(OP_SORTED, 32'sh8000_0000, 5'd0);
		issue(OP_SORTED, 32'sd0, 5'd17);
		issue(OP_SORTED, -32'sd1, 5'd0);
		issue(OP_LOCATE, 32'sd0, 5'd0);
		issue(OP_LOCATE, 32'sh7fff_ffff, 5'd0);
		issue(OP_LOCATE, 32'sh8000_0000, 5'd0);
		issue(OP_LOCATE, 32'sd12345, 5'd0);
		issue(OP_INSERT, 32'sh5555_5555, 5'd0);
		issue(OP_INSERT, 32'shAAAA_AAAA, 5'd6);
		issue(OP_INSERT, 32'sd3, 5'd3);
		issue(OP_LOCATE, 32'shAAAA_AAAA, 5'd0);
		issue(OP_DELETE, 32'sd0, 5'd0);
		issue(OP_DELETE, 32'sd0, 5'd6);
		issue(OP_DELETE, 32'sd0, 5'd6);
		issue(OP_DELETE, 32'sd0, 5'd16);
		issue(OP_LOCATE, 32'sd3, 5'd31);

		// Random: alternate growing and draining stretches so the list fills and empties
		growing  = 1'b1;
		seg_left = 0;
		for (phase = 0; phase < 4; phase++) begin
			for (n = 0; n < RANDOM_REQUESTS / 4; n++) begin
				if (seg_left == 0) begin
					growing  = !growing;
					seg_left = $urandom_range(20, 60);
				end
				seg_left--;
				f = fill_now;
				r = $urandom_range(99);
				pos = (f > 0) ? 5'($urandom_range(f - 1)) : 5'd0;
				if (r >= 90) begin
					req_op = op_t'($urandom_range(3));
					pos    = 5'($urandom_range(31));
				end else if (growing) begin
					if (r < 35) begin
						req_op = OP_INSERT;
						pos    = 5'($urandom_range(f));
					end else if (r < 65) begin
						req_op = OP_SORTED;
					end else if (r < 80) begin
						req_op = OP_LOCATE;
					end else begin
						req_op = OP_DELETE;
					end
				end else begin
					if (r < 45) begin
						req_op = OP_DELETE;
					end else if (r < 60) begin
						req_op = OP_INSERT;
						pos    = 5'($urandom_range(f));
					end else if (r < 70) begin
						req_op = OP_SORTED;
					end else begin
						req_op = OP_LOCATE;
					end
				end
				idle_gap(idle_pct[phase]);
				issue(req_op, (r >= 95) ? $signed($urandom) : pick_word(), pos);
			end
		end

		// Drain and give the verdict
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("** positional_sorted_list_table: PASSED **");
		else
			$display("** positional_sorted_list_table: FAILED **");
		$finish;
	end

endmodule
